// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define PRQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("prq assertion failed");

// the antecedent implies the delayed consequent
`define PRQ_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("prq assertion failed");

`endif

// File: rtl/prq_pkg.sv
// types and constants for the priority bitmap run queue
package prq_pkg;

   localparam int NUM_THREADS = 32;
   localparam int NUM_LEVELS  = 32;

   localparam int THREAD_W = 5;
   localparam int LEVEL_W  = 5;
   localparam int QUANT_W  = 8;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [QUANT_W-1:0] QUANTUM_RELOAD_RESET = QUANT_W'(10);

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [THREAD_W-1:0] thread_id;
      logic [LEVEL_W-1:0]  priority_req;
      logic [QUANT_W-1:0]  quantum_left;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [THREAD_W-1:0] next_thread;
      logic [QUANT_W-1:0]  quantum_out;
   } rsp_type;

endpackage

// File: rtl/priority_bitmap_run_queue.sv
// priority bitmap run queue: per-level linked lists with a non-empty level mask
//
//   channel   ports                          direction  transfer when
//   request   start, busy, req_data          in         start && !busy
//   response  rsp_strobe, rsp_data           out        rsp_strobe
//   csr       csr_we, csr_wdata              in         csr_we
//
// one item per cycle; busy is always low
// the result shows after the request transfer, through the input register and then the result register
// all list updates for an item happen in the single pass between those registers
// synchronous active-high reset clears the mask, queued bits and strobes
// no stalls on either side; the receiver takes every result
module priority_bitmap_run_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  prq_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output prq_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [prq_pkg::QUANT_W-1:0]   csr_wdata
);
   import prq_pkg::*;

   logic                 req_valid_ff;
   req_type              req_ff;
   logic [QUANT_W-1:0]   reload_ff;
   logic [NUM_LEVELS-1:0]  mask_ff, mask_in;
   logic [NUM_THREADS-1:0] queued_ff, queued_in;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [THREAD_W-1:0] head_ff  [NUM_LEVELS];
   logic [THREAD_W-1:0] tail_ff  [NUM_LEVELS];
   logic [THREAD_W-1:0] next_ff  [NUM_THREADS];
   logic [THREAD_W-1:0] prev_ff  [NUM_THREADS];
   logic [LEVEL_W-1:0]  level_ff [NUM_THREADS];

   logic                head_we, tail_we, next_we, prev_we, level_we;
   logic [LEVEL_W-1:0]  head_waddr, tail_waddr;
   logic [THREAD_W-1:0] next_waddr, prev_waddr;
   logic [THREAD_W-1:0] head_wdata, tail_wdata, next_wdata, prev_wdata;

   logic [THREAD_W-1:0] t;
   logic [LEVEL_W-1:0]  lvl_req, cur_lvl, pick_lvl, head_raddr, tail_raddr;
   logic [THREAD_W-1:0] p, n, head_rd, tail_rd;
   logic                thread_ok, lvl_ok, lvl_busy, at_head, at_tail;

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign t       = req_ff.thread_id;
   assign lvl_req = req_ff.priority_req;
   assign cur_lvl = level_ff[t];
   assign p       = prev_ff[t];
   assign n       = next_ff[t];

   assign thread_ok = (int'(t) < NUM_THREADS);
   assign lvl_ok    = (int'(lvl_req) < NUM_LEVELS);
   assign lvl_busy  = mask_ff[lvl_req];

   // highest non-empty level
   always_comb begin
      pick_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (mask_ff[i]) begin
            pick_lvl = LEVEL_W'(i);
         end
      end
   end

   always_comb begin
      case (req_ff.func)
         FUNC_INSERT: begin
            head_raddr = lvl_req;
         end
         FUNC_REMOVE: begin
            head_raddr = cur_lvl;
         end
         default: begin
            head_raddr = pick_lvl;
         end
      endcase
   end

   assign tail_raddr = (req_ff.func == FUNC_REMOVE) ? cur_lvl : lvl_req;
   assign head_rd    = head_ff[head_raddr];
   assign tail_rd    = tail_ff[tail_raddr];
   assign at_head    = (head_rd == t);
   assign at_tail    = (tail_rd == t);

   always_comb begin
      mask_in    = mask_ff;
      queued_in  = queued_ff;
      rsp_in     = '{status: ST_INVALID, next_thread: '0, quantum_out: '0};
      head_we    = 1'b0;
      tail_we    = 1'b0;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      level_we   = 1'b0;
      head_waddr = lvl_req;
      tail_waddr = lvl_req;
      next_waddr = t;
      prev_waddr = t;
      head_wdata = t;
      tail_wdata = t;
      next_wdata = t;
      prev_wdata = t;
      if (req_valid_ff) begin
         case (req_ff.func)
            FUNC_INSERT: begin
               if (thread_ok && lvl_ok && !queued_ff[t]) begin
                  rsp_in.status    = ST_DONE;
                  level_we         = 1'b1;
                  queued_in[t]     = 1'b1;
                  mask_in[lvl_req] = 1'b1;
                  if (req_ff.quantum_left != '0) begin
                     rsp_in.quantum_out = req_ff.quantum_left;
                     head_we = 1'b1;
                     if (!lvl_busy) begin
                        tail_we = 1'b1;
                     end else begin
                        next_we    = 1'b1;
                        next_wdata = head_rd;
                        prev_we    = 1'b1;
                        prev_waddr = head_rd;
                     end
                  end else begin
                     rsp_in.quantum_out = reload_ff;
                     tail_we = 1'b1;
                     if (!lvl_busy) begin
                        head_we = 1'b1;
                     end else begin
                        prev_we    = 1'b1;
                        prev_wdata = tail_rd;
                        next_we    = 1'b1;
                        next_waddr = tail_rd;
                     end
                  end
               end
            end
            FUNC_REMOVE: begin
               if (thread_ok && queued_ff[t]) begin
                  rsp_in.status = ST_DONE;
                  queued_in[t]  = 1'b0;
                  if (at_head && at_tail) begin
                     mask_in[cur_lvl] = 1'b0;
                  end else if (at_head) begin
                     head_we    = 1'b1;
                     head_waddr = cur_lvl;
                     head_wdata = n;
                  end else if (at_tail) begin
                     tail_we    = 1'b1;
                     tail_waddr = cur_lvl;
                     tail_wdata = p;
                  end else begin
                     next_we    = 1'b1;
                     next_waddr = p;
                     next_wdata = n;
                     prev_we    = 1'b1;
                     prev_waddr = n;
                     prev_wdata = p;
                  end
               end
            end
            FUNC_PICK: begin
               if (mask_ff != '0) begin
                  rsp_in.status      = ST_DONE;
                  rsp_in.next_thread = head_rd;
               end else begin
                  rsp_in.status = ST_EMPTY;
               end
            end
            default: begin
               rsp_in.status = ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         reload_ff     <= QUANTUM_RELOAD_RESET;
         mask_ff       <= '0;
         queued_ff     <= '0;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         mask_ff       <= mask_in;
         queued_ff     <= queued_in;
         if (csr_we) begin
            reload_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // link storage, written without reset
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[head_waddr] <= head_wdata;
      end
      if (tail_we) begin
         tail_ff[tail_waddr] <= tail_wdata;
      end
      if (next_we) begin
         next_ff[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_ff[prev_waddr] <= prev_wdata;
      end
      if (level_we) begin
         level_ff[t] <= lvl_req;
      end
   end

endmodule

// File: rtl/prq_checker.sv
// port-level checker for the priority bitmap run queue, with its bind
`include "assert_macros.svh"

module prq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input prq_pkg::req_type              req_data,
   input logic                          rsp_strobe,
   input prq_pkg::rsp_type              rsp_data,
   input logic                          csr_we,
   input logic [prq_pkg::QUANT_W-1:0]   csr_wdata
);
   import prq_pkg::*;

   logic req_xfer;
   logic failed;

   assign req_xfer = start && !busy;
   assign failed   = rsp_strobe && (rsp_data.status != ST_DONE);

   // every request transfer gives one later result
   `PRQ_ASSERT_DELAY(a_rsp_follows_req, clock, reset, req_xfer, 2, rsp_strobe)
   // no result without a request transfer
   `PRQ_ASSERT_DELAY(a_no_spurious_rsp, clock, reset, !req_xfer, 2, !rsp_strobe)
   // status stays within its codes
   `PRQ_ASSERT(a_status_code, clock, reset, !rsp_strobe || rsp_data.status != 2'd3)
   // a failed or empty request returns zero payload
   `PRQ_ASSERT(a_fail_zero, clock, reset,
               !failed || (rsp_data.next_thread == '0 && rsp_data.quantum_out == '0))

endmodule

bind priority_bitmap_run_queue prq_checker u_prq_checker (.*);

// File: test/prq_checker.sv
// checker for the run queue: watches request, result and csr transfers, predicts and compares
module prq_run_queue_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  prq_pkg::req_type             req_data,
   input  logic                         rsp_strobe,
   input  prq_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [prq_pkg::QUANT_W-1:0]  csr_wdata,
   output int                           mismatches,
   output int                           outstanding
);
   import prq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [QUANT_W-1:0]  reload_q;
   logic [NUM_LEVELS-1:0] lvl_mask;
   logic [THREAD_W-1:0] lvl_first [NUM_LEVELS];
   logic [THREAD_W-1:0] lvl_last [NUM_LEVELS];
   logic [THREAD_W-1:0] link_fwd [NUM_THREADS];
   logic [THREAD_W-1:0] link_back [NUM_THREADS];
   logic                is_queued [NUM_THREADS];
   logic [LEVEL_W-1:0]  queued_lvl [NUM_THREADS];

   rsp_type due_answers [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic rsp_type sched_step(input req_type op);
      rsp_type r;
      logic [THREAD_W-1:0] t;
      logic [THREAD_W-1:0] p;
      logic [THREAD_W-1:0] n;
      logic [LEVEL_W-1:0] lv;
      logic found;
      r.status = ST_INVALID;
      r.next_thread = '0;
      r.quantum_out = '0;
      t = op.thread_id;
      if (op.func == FUNC_INSERT) begin
         lv = op.priority_req;
         if (int'(t) < NUM_THREADS && int'(lv) < NUM_LEVELS && !is_queued[t]) begin
            if (op.quantum_left != '0) begin
               if (lvl_mask[lv]) begin
                  link_fwd[t] = lvl_first[lv];
                  link_back[lvl_first[lv]] = t;
               end else begin
                  lvl_last[lv] = t;
               end
               lvl_first[lv] = t;
               r.quantum_out = op.quantum_left;
            end else begin
               if (lvl_mask[lv]) begin
                  link_back[t] = lvl_last[lv];
                  link_fwd[lvl_last[lv]] = t;
               end else begin
                  lvl_first[lv] = t;
               end
               lvl_last[lv] = t;
               r.quantum_out = reload_q;
            end
            lvl_mask[lv] = 1'b1;
            queued_lvl[t] = lv;
            is_queued[t] = 1'b1;
            r.status = ST_DONE;
         end
      end else if (op.func == FUNC_REMOVE) begin
         if (int'(t) < NUM_THREADS && is_queued[t]) begin
            lv = queued_lvl[t];
            p = link_back[t];
            n = link_fwd[t];
            if (lvl_first[lv] == t && lvl_last[lv] == t) begin
               lvl_mask[lv] = 1'b0;
            end else if (lvl_first[lv] == t) begin
               lvl_first[lv] = n;
            end else if (lvl_last[lv] == t) begin
               lvl_last[lv] = p;
            end else begin
               link_fwd[p] = n;
               link_back[n] = p;
            end
            is_queued[t] = 1'b0;
            r.status = ST_DONE;
         end
      end else if (op.func == FUNC_PICK) begin
         r.status = ST_EMPTY;
         found = 1'b0;
         for (int l = NUM_LEVELS - 1; l >= 0 && !found; l--) begin
            if (lvl_mask[l]) begin
               r.next_thread = lvl_first[l];
               r.status = ST_DONE;
               found = 1'b1;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         reload_q = QUANTUM_RELOAD_RESET;
         lvl_mask = '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_first[i] = '0;
            lvl_last[i] = '0;
         end
         for (int i = 0; i < NUM_THREADS; i++) begin
            link_fwd[i] = '0;
            link_back[i] = '0;
            is_queued[i] = 1'b0;
            queued_lvl[i] = '0;
         end
         due_answers.delete();
      end else begin
         if (rsp_strobe) begin
            if (due_answers.size() == 0) begin
               report_mismatch("result transfer with nothing pending");
            end else begin
               want = due_answers.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.next_thread !== want.next_thread)
                  report_mismatch($sformatf("next_thread got %0d want %0d",
                                            rsp_data.next_thread, want.next_thread));
               if (rsp_data.quantum_out !== want.quantum_out)
                  report_mismatch($sformatf("quantum_out got %0d want %0d",
                                            rsp_data.quantum_out, want.quantum_out));
            end
         end
         if (start && !busy)
            due_answers.push_back(sched_step(req_data));
         if (csr_we)
            reload_q = csr_wdata;
      end
      outstanding = due_answers.size();
   end

endmodule

// File: test/tb_priority_bitmap_run_queue.sv
// testbench top for the run queue: clock, reset, stimulus and verdict
module tb_priority_bitmap_run_queue;
   import prq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int OPS_PER_PHASE = 316;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_we;
   logic [QUANT_W-1:0] csr_wdata;
   int                 mismatches;
   int                 outstanding;
   logic               req_taken = 1'b0;

   logic [NUM_THREADS-1:0] queued_hint = '0;
   int                     queued_total = 0;
   logic                   burst = 1'b0;
   logic [QUANT_W-1:0]     reload_plan [6];

   always #4 clock = ~clock;

   priority_bitmap_run_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   prq_run_queue_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      req_taken <= start && !busy && !reset;
   end

   function automatic req_type make_op(input logic [FUNC_W-1:0] f, input int t,
                                       input int lv, input int q);
      req_type op;
      op.func = f;
      op.thread_id = THREAD_W'(t);
      op.priority_req = LEVEL_W'(lv);
      op.quantum_left = QUANT_W'(q);
      return op;
   endfunction

   function automatic req_type random_op();
      req_type op;
      int roll;
      int base;
      int idx;
      logic want_queued;
      logic found;
      op.thread_id = THREAD_W'($urandom_range(0, NUM_THREADS - 1));
      case ($urandom_range(0, 3))
         0, 1: op.priority_req = LEVEL_W'($urandom_range(0, 3));
         2: op.priority_req = LEVEL_W'($urandom_range(NUM_LEVELS - 4, NUM_LEVELS - 1));
         default: op.priority_req = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
      endcase
      case ($urandom_range(0, 4))
         0, 1: op.quantum_left = '0;
         2: op.quantum_left = '1;
         default: op.quantum_left = QUANT_W'($urandom_range(1, 255));
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         op.func = FUNC_UNUSED;
      end else if (roll < 24) begin
         op.func = FUNC_PICK;
      end else begin
         op.func = ($urandom_range(0, NUM_THREADS - 1) >= queued_total) ? FUNC_INSERT
                                                                          : FUNC_REMOVE;
         // mostly well-formed: insert an unqueued thread, remove a queued one
         if ($urandom_range(0, 9) != 0) begin
            want_queued = (op.func == FUNC_REMOVE);
            base = $urandom_range(0, NUM_THREADS - 1);
            found = 1'b0;
            for (int k = 0; k < NUM_THREADS && !found; k++) begin
               idx = (base + k) % NUM_THREADS;
               if (queued_hint[idx] == want_queued) begin
                  op.thread_id = THREAD_W'(idx);
                  found = 1'b1;
               end
            end
         end
      end
      return op;
   endfunction

   task automatic send_op(input req_type op);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= op;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
      if (op.func == FUNC_INSERT && !queued_hint[op.thread_id]) begin
         queued_hint[op.thread_id] = 1'b1;
         queued_total++;
      end else if (op.func == FUNC_REMOVE && queued_hint[op.thread_id]) begin
         queued_hint[op.thread_id] = 1'b0;
         queued_total--;
      end
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 && guard < 200) begin
         @(negedge clock);
         guard++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed part runs with the reset reload value
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_REMOVE, 0, 0, 0));
      send_op(make_op(FUNC_INSERT, 0, 0, 0));
      send_op(make_op(FUNC_INSERT, 0, 31, 255));
      send_op(make_op(FUNC_PICK, 31, 31, 255));
      send_op(make_op(FUNC_INSERT, 31, 31, 255));
      send_op(make_op(FUNC_INSERT, 5, 31, 1));
      send_op(make_op(FUNC_INSERT, 6, 31, 0));
      send_op(make_op(FUNC_INSERT, 7, 31, 0));
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_REMOVE, 31, 0, 0));
      send_op(make_op(FUNC_REMOVE, 5, 0, 0));
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_REMOVE, 7, 0, 0));
      send_op(make_op(FUNC_UNUSED, 31, 31, 255));
      send_op(make_op(FUNC_REMOVE, 6, 0, 0));
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_INSERT, 16, 16, 128));
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_REMOVE, 16, 0, 0));
      send_op(make_op(FUNC_REMOVE, 0, 0, 0));
      send_op(make_op(FUNC_PICK, 0, 0, 0));
      send_op(make_op(FUNC_REMOVE, 31, 0, 0));

      reload_plan[0] = 8'd255;
      reload_plan[1] = 8'd0;
      reload_plan[2] = 8'd1;
      reload_plan[3] = QUANT_W'($urandom_range(2, 254));
      reload_plan[4] = QUANT_W'($urandom_range(0, 255));
      reload_plan[5] = QUANTUM_RELOAD_RESET;

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         csr_wdata <= reload_plan[ph];
         csr_we <= 1'b1;
         @(negedge clock);
         csr_we <= 1'b0;
         for (int i = 0; i < OPS_PER_PHASE; i++) begin
            if (i % 50 == 0)
               burst = ($urandom_range(0, 2) == 0);
            send_op(random_op());
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
